>>> hw/rtl/tlife_pkg.sv
`timescale 1ns / 1ps

package tlife_pkg;

  localparam int ROWS  = 16;
  localparam int COLS  = 16;
  localparam int BANKS = 3;
  localparam int DEPTH = BANKS * ROWS;
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(DEPTH);
  // counts the ROWS+2 window reads of a step, plus the stop value
  localparam int CW    = $clog2(ROWS + 3);
  localparam int ECW   = $clog2(ROWS + 1);

  localparam logic [3:0] BIRTH_N   = 4'd3;
  localparam logic [3:0] SURVIVE_N = 4'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef logic [COLS-1:0] row_t;
  typedef logic [RW-1:0]   ridx_t;
  typedef logic [1:0]      bank_t;
  typedef logic [AW-1:0]   addr_t;

  localparam bank_t BANK_A = 2'd0;
  localparam bank_t BANK_B = 2'd1;
  localparam bank_t BANK_C = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_row_index;
    logic [15:0] out_row_bits;
    logic        last;
    logic        stuck;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    row_t  wdata;
    logic  re_a;
    addr_t raddr_a;
    logic  re_b;
    addr_t raddr_b;
  } mem_req_t;

  function automatic addr_t grid_addr(bank_t b, ridx_t r);
    return AW'(AW'(b) * AW'(ROWS) + AW'(r));
  endfunction

endpackage

>>> hw/rtl/toroidal_life_step_with_stall_detect.sv
// Game of Life on a 16x16 torus (birth on 3, survival on 2 or 3), with the
// current and previous generations kept in one three-bank grid memory. A load
// item writes one row of the current grid. A step item streams the current
// grid through a three-row window, one memory read per cycle, writes the new
// generation into the spare bank and compares it with the current and
// previous rows as it goes; if it matches either of them in full the step is
// stuck and nothing changes, otherwise the banks rotate and no copy is made.
// A step then reports all 16 rows, one per cycle while the output does not
// stall, out of read port A. The input stays stalled through the ROWS+2
// window reads and their read latency, then the ROWS report reads. The last
// row may still wait at the output while the next item is taken. Grid
// contents read as dead after reset through per-entry valid bits, so there
// is no clearing pass.
`timescale 1ns / 1ps

module toroidal_life_step_with_stall_detect import tlife_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  state_t    state_r, state_nxt;
  bank_t     cur_bank_r, prev_bank_r, new_bank_r;
  logic [CW-1:0]  cnt_r;
  logic           iss_vld_r;
  logic [CW-1:0]  iss_cnt_r;
  row_t      win_up_r, win_mid_r;
  logic      diff_prev_r, diff_cur_r;
  logic      stuck_r;
  logic [ECW-1:0] emit_cnt_r;
  logic      pend_r;
  ridx_t     pend_row_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  mem_req_t  mem_req;
  row_t      rdata_a, rdata_b;
  row_t      fresh_row;
  ridx_t     calc_row, rd_row_a;
  logic      accept_in, load_we, step_go;
  logic      issue, calc_en, calc_done;
  logic      diff_prev_all, diff_cur_all, stuck_calc;
  logic      out_free, move, emit_issue;

  tlife_gridmem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // window: rows r-1, r (registered) and r+1 (just read)
  tlife_rowrule u_rule (
    .up_row  (win_up_r),
    .mid_row (win_mid_r),
    .dn_row  (rdata_a),
    .nxt_row (fresh_row)
  );

  assign accept_in = in_valid && !in_stall;
  assign load_we   = accept_in && (in_item.kind == KIND_LOAD)
                     && (int'(in_item.row_index) < ROWS);
  assign step_go   = accept_in && (in_item.kind == KIND_STEP);

  assign issue     = (state_r == ST_CALC) && (cnt_r <= CW'(ROWS + 1));
  assign calc_en   = iss_vld_r && (iss_cnt_r >= CW'(2));
  assign calc_done = iss_vld_r && (iss_cnt_r == CW'(ROWS + 1));
  assign calc_row  = RW'(iss_cnt_r - CW'(2));

  // read order ROWS-1, 0, 1, ..., ROWS-1, 0 wraps the top and bottom edges
  always_comb begin
    if (cnt_r == '0) begin
      rd_row_a = RW'(ROWS - 1);
    end else if (cnt_r == CW'(ROWS + 1)) begin
      rd_row_a = '0;
    end else begin
      rd_row_a = RW'(cnt_r - CW'(1));
    end
  end

  assign diff_prev_all = diff_prev_r || (calc_en && (fresh_row != rdata_b));
  assign diff_cur_all  = diff_cur_r  || (calc_en && (fresh_row != win_mid_r));
  assign stuck_calc    = !diff_prev_all || !diff_cur_all;

  assign out_free   = !out_valid_r || !out_stall;
  assign move       = pend_r && out_free;
  assign emit_issue = (state_r == ST_EMIT) && (emit_cnt_r < ECW'(ROWS))
                      && (!pend_r || move);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (step_go) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (calc_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if ((emit_cnt_r == ECW'(ROWS)) && !pend_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state_r != ST_IDLE);
    mem_req         = '0;
    mem_req.we      = load_we || ((state_r == ST_CALC) && calc_en);
    mem_req.waddr   = load_we ? grid_addr(cur_bank_r, RW'(in_item.row_index))
                              : grid_addr(new_bank_r, calc_row);
    mem_req.wdata   = load_we ? COLS'(in_item.row_bits) : fresh_row;
    mem_req.re_a    = issue || emit_issue;
    mem_req.raddr_a = (state_r == ST_EMIT)
                      ? grid_addr(cur_bank_r, emit_cnt_r[RW-1:0])
                      : grid_addr(cur_bank_r, rd_row_a);
    mem_req.re_b    = issue;
    mem_req.raddr_b = grid_addr(prev_bank_r, RW'(cnt_r - CW'(2)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_bank_r  <= BANK_A;
      prev_bank_r <= BANK_B;
      new_bank_r  <= BANK_C;
      cnt_r       <= '0;
      iss_vld_r   <= 1'b0;
      emit_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iss_vld_r <= issue;
      if (step_go) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (calc_done) begin
        emit_cnt_r <= '0;
        if (!stuck_calc) begin
          prev_bank_r <= cur_bank_r;
          cur_bank_r  <= new_bank_r;
          new_bank_r  <= prev_bank_r;
        end
      end else if (emit_issue) begin
        emit_cnt_r <= emit_cnt_r + ECW'(1);
      end
      if (emit_issue) begin
        pend_r <= 1'b1;
      end else if (move) begin
        pend_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    iss_cnt_r <= cnt_r;
    if (iss_vld_r) begin
      win_up_r  <= win_mid_r;
      win_mid_r <= rdata_a;
    end
    if (step_go) begin
      diff_prev_r <= 1'b0;
      diff_cur_r  <= 1'b0;
    end else if (state_r == ST_CALC) begin
      diff_prev_r <= diff_prev_all;
      diff_cur_r  <= diff_cur_all;
    end
    if (calc_done) begin
      stuck_r <= stuck_calc;
    end
    if (emit_issue) begin
      pend_row_r <= emit_cnt_r[RW-1:0];
    end
    if (move) begin
      out_item_r.out_row_index <= 4'(pend_row_r);
      out_item_r.out_row_bits  <= 16'(rdata_a);
      out_item_r.last          <= (pend_row_r == RW'(ROWS - 1));
      out_item_r.stuck         <= stuck_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_step_starts_calc: assert property (
    @(posedge clk) disable iff (!rst_n)
    step_go |=> (state_r == ST_CALC)
  ) else $error("step item did not start the generation pass");

  a_banks_distinct: assert property (
    @(posedge clk) disable iff (!rst_n)
    (cur_bank_r != prev_bank_r) && (cur_bank_r != new_bank_r)
      && (prev_bank_r != new_bank_r)
  ) else $error("grid bank roles overlap");

  a_rotate_only_unstuck: assert property (
    @(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && ($past(state_r) == ST_CALC)
      && (cur_bank_r != $past(cur_bank_r))) |-> !stuck_r
  ) else $error("grids rotated on a stuck step");

  a_no_new_write_outside_calc: assert property (
    @(posedge clk) disable iff (!rst_n)
    (mem_req.we && (state_r != ST_CALC)) |-> load_we
  ) else $error("grid write outside load or generation pass");

endmodule

>>> hw/rtl/tlife_gridmem.sv
`timescale 1ns / 1ps

module tlife_gridmem import tlife_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mem_req_t req,
  output row_t     rdata_a,
  output row_t     rdata_b
);

  row_t             mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  row_t             rdata_a_r;
  row_t             rdata_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    // never-written entries read as dead cells
    if (req.re_a) begin
      rdata_a_r <= valid_r[req.raddr_a] ? mem_r[req.raddr_a] : '0;
    end
    if (req.re_b) begin
      rdata_b_r <= valid_r[req.raddr_b] ? mem_r[req.raddr_b] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> hw/rtl/tlife_rowrule.sv
`timescale 1ns / 1ps

module tlife_rowrule import tlife_pkg::*; (
  input  row_t up_row,
  input  row_t mid_row,
  input  row_t dn_row,
  output row_t nxt_row
);

  for (genvar c = 0; c < COLS; c++) begin : g_col
    localparam int LF = (c == 0) ? COLS - 1 : c - 1;
    localparam int RT = (c == COLS - 1) ? 0 : c + 1;
    logic [3:0] n;

    assign n = 4'(up_row[LF]) + 4'(up_row[c]) + 4'(up_row[RT])
             + 4'(mid_row[LF]) + 4'(mid_row[RT])
             + 4'(dn_row[LF]) + 4'(dn_row[c]) + 4'(dn_row[RT]);
    assign nxt_row[c] = (n == BIRTH_N) || (mid_row[c] && (n == SURVIVE_N));
  end

endmodule
